// ===== hw/rtl/rlps_pkg.sv =====
// ----------------------------------------------------------------------------
// rlps_pkg
// Types, constants and helpers shared by the random-last permutation selector.
// ----------------------------------------------------------------------------
package rlps_pkg;

  localparam int MAX_JOINS = 5;
  localparam int IDX_W     = 7;
  localparam int CFG_W     = 3;
  localparam int JOIN_W    = $clog2(MAX_JOINS + 1);
  localparam int FACT_W    = 16;
  localparam logic [CFG_W-1:0] JOIN_COUNT_RESET = 3'd5;

  typedef enum logic {
    ACT_SET   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] permutation_index;
    logic             join_is_random;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_permutation;
    logic             index_error;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [MAX_JOINS-1:0] seq;
    logic [JOIN_W-1:0]    first;
    logic                 last;
  } walk_stat_t;

  // factorial of a small join count
  function automatic logic [FACT_W-1:0] fact(input logic [JOIN_W-1:0] n);
    logic [FACT_W-1:0] f;
    f = FACT_W'(1);
    for (int i = 2; i <= MAX_JOINS; i++) begin
      if (i <= int'(n)) begin
        f = FACT_W'(f * FACT_W'(i));
      end
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/rlps_walker.sv =====
// ----------------------------------------------------------------------------
// rlps_walker
// Steps through permutations in lexicographic order, one per cycle while step
// is high, with a mixed-radix digit counter; gives the current flag sequence.
// ----------------------------------------------------------------------------
module rlps_walker (
  input  logic                            clk,
  input  rlps_pkg::walk_ctrl_t            ctrl,
  input  logic [rlps_pkg::JOIN_W-1:0]     joins,
  input  logic [rlps_pkg::MAX_JOINS-1:0]  flags,
  output rlps_pkg::walk_stat_t            stat
);

  logic [rlps_pkg::JOIN_W-1:0] digit      [rlps_pkg::MAX_JOINS];
  logic [rlps_pkg::JOIN_W-1:0] digit_next [rlps_pkg::MAX_JOINS];
  logic [rlps_pkg::IDX_W-1:0]  idx;
  logic                        last;
  logic [rlps_pkg::MAX_JOINS-1:0] seq;

  // top digit of position p has radix (joins - p)
  function automatic logic [rlps_pkg::JOIN_W-1:0] digit_max(
    input logic [rlps_pkg::JOIN_W-1:0] n,
    input int                          p
  );
    int m;
    m = int'(n) - 1 - p;
    return (m > 0) ? rlps_pkg::JOIN_W'(m) : '0;
  endfunction

  // mixed-radix increment, carry from the last position toward the first
  always_comb begin
    logic carry;
    carry = 1'b1;
    last  = 1'b1;
    for (int p = rlps_pkg::MAX_JOINS - 1; p >= 0; p--) begin
      digit_next[p] = digit[p];
      if (p < int'(joins)) begin
        if (digit[p] != digit_max(joins, p)) begin
          last = 1'b0;
        end
        if (carry) begin
          if (digit[p] == digit_max(joins, p)) begin
            digit_next[p] = '0;
          end else begin
            digit_next[p] = digit[p] + rlps_pkg::JOIN_W'(1);
            carry = 1'b0;
          end
        end
      end
    end
  end

  // pick joins from the remaining list; position 0 lands in the msb
  always_comb begin
    logic [rlps_pkg::MAX_JOINS-1:0] avail;
    logic [rlps_pkg::MAX_JOINS-1:0] avail_next;
    logic                           bit_sel;
    avail = flags;
    seq   = '0;
    for (int p = 0; p < rlps_pkg::MAX_JOINS; p++) begin
      bit_sel    = 1'b0;
      avail_next = avail;
      for (int i = 0; i < rlps_pkg::MAX_JOINS; i++) begin
        if (digit[p] == rlps_pkg::JOIN_W'(i)) begin
          bit_sel = avail[i];
        end
        if (rlps_pkg::JOIN_W'(i) >= digit[p]) begin
          avail_next[i] = (i + 1 < rlps_pkg::MAX_JOINS) ?
                          avail[(i + 1) % rlps_pkg::MAX_JOINS] : 1'b0;
        end
      end
      if (p < int'(joins)) begin
        seq[rlps_pkg::MAX_JOINS-1-p] = bit_sel;
        avail = avail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int p = 0; p < rlps_pkg::MAX_JOINS; p++) begin
        digit[p] <= '0;
      end
      idx <= '0;
    end else if (ctrl.step) begin
      for (int p = 0; p < rlps_pkg::MAX_JOINS; p++) begin
        digit[p] <= digit_next[p];
      end
      idx <= idx + rlps_pkg::IDX_W'(1);
    end
  end

  assign stat.idx   = idx;
  assign stat.seq   = seq;
  assign stat.first = digit[0];
  assign stat.last  = last;

endmodule

// ===== hw/rtl/random_last_permutation_selector.sv =====
// ----------------------------------------------------------------------------
// random_last_permutation_selector
// Keeps one random flag per join; sets a flag through the first join of a
// permutation, or scans all permutations for the one that puts random joins
// last, keeping the given index unless another is strictly better.
// ----------------------------------------------------------------------------
//  channel   signals                         moves
//  req       req_valid / req_stall / req     set or query transaction
//  rsp       rsp_valid / rsp_stall / rsp     chosen index and error flag
//  cfg       cfg_write / cfg_data            join_count register
//
//  a query walks all n! permutations, one per cycle
//  a set walks up to its own index; a bad index skips the walk
//  req_stall is high while busy
//  rst is synchronous; flags clear to not random and join_count returns to 5
//  a result waits in the output register while rsp_stall is high
// ----------------------------------------------------------------------------
module random_last_permutation_selector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rlps_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  rlps_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output rlps_pkg::rsp_t                rsp
);

  rlps_pkg::state_t               state, state_next;
  logic [rlps_pkg::CFG_W-1:0]     join_count;
  logic [rlps_pkg::JOIN_W-1:0]    joins;
  logic [rlps_pkg::MAX_JOINS-1:0] flags;
  logic                           act;
  logic [rlps_pkg::IDX_W-1:0]     idx;
  logic                           rand_flag;
  logic                           err;
  logic [rlps_pkg::MAX_JOINS-1:0] min_seq;
  logic [rlps_pkg::IDX_W-1:0]     min_idx;
  logic [rlps_pkg::MAX_JOINS-1:0] own_seq;
  rlps_pkg::walk_ctrl_t           ctrl;
  rlps_pkg::walk_stat_t           stat;
  logic                           accept;
  logic                           bad_index;
  logic                           load_rsp;
  logic                           write_flag;

  always_comb begin
    if (join_count == '0) begin
      joins = rlps_pkg::JOIN_W'(1);
    end else if (int'(join_count) > rlps_pkg::MAX_JOINS) begin
      joins = rlps_pkg::JOIN_W'(rlps_pkg::MAX_JOINS);
    end else begin
      joins = rlps_pkg::JOIN_W'(join_count);
    end
  end

  assign req_stall = (state != rlps_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign bad_index = {{(rlps_pkg::FACT_W - rlps_pkg::IDX_W){1'b0}}, req.permutation_index}
                     >= rlps_pkg::fact(joins);

  rlps_walker u_walker (
    .clk   (clk),
    .ctrl  (ctrl),
    .joins (joins),
    .flags (flags),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    load_rsp   = 1'b0;
    write_flag = 1'b0;
    unique case (state)
      rlps_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.clear = 1'b1;
          state_next = bad_index ? rlps_pkg::ST_DONE : rlps_pkg::ST_WALK;
        end
      end
      rlps_pkg::ST_WALK: begin
        ctrl.step = 1'b1;
        if (act == rlps_pkg::ACT_SET) begin
          if (stat.idx == idx) begin
            write_flag = 1'b1;
            state_next = rlps_pkg::ST_IDLE;
          end
        end else if (stat.last) begin
          state_next = rlps_pkg::ST_DONE;
        end
      end
      rlps_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = rlps_pkg::ST_IDLE;
        end
      end
      default: state_next = rlps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      join_count <= rlps_pkg::JOIN_COUNT_RESET;
      flags      <= '0;
    end else begin
      if (cfg_write) begin
        join_count <= cfg_data;
      end
      if (write_flag) begin
        for (int j = 0; j < rlps_pkg::MAX_JOINS; j++) begin
          if (stat.first == rlps_pkg::JOIN_W'(j)) begin
            flags[j] <= rand_flag;
          end
        end
      end
    end
  end

  // transaction fields and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= req.action;
      idx       <= req.permutation_index;
      rand_flag <= req.join_is_random;
      err       <= bad_index;
    end
    if (state == rlps_pkg::ST_WALK) begin
      // lower flag sequence puts random joins later; first hit wins ties
      if (stat.idx == '0 || stat.seq < min_seq) begin
        min_seq <= stat.seq;
        min_idx <= stat.idx;
      end
      if (stat.idx == idx) begin
        own_seq <= stat.seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.index_error <= err;
      if (err) begin
        rsp.chosen_permutation <= '0;
      end else if (own_seq == min_seq) begin
        rsp.chosen_permutation <= idx;
      end else begin
        rsp.chosen_permutation <= min_idx;
      end
    end
  end

endmodule

// ===== hw/rtl/rlps_checker.sv =====
// ----------------------------------------------------------------------------
// rlps_checker
// Port-level checks for the random-last permutation selector.
// ----------------------------------------------------------------------------
module rlps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input rlps_pkg::req_t             req,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input rlps_pkg::rsp_t             rsp
);

  localparam logic [rlps_pkg::FACT_W-1:0] FACT_MAX =
    rlps_pkg::fact(rlps_pkg::JOIN_W'(rlps_pkg::MAX_JOINS));

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // an error response carries index zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.index_error |-> rsp.chosen_permutation == '0)
    else $error("error response with nonzero index");

  // a chosen index is below the largest permutation count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.index_error |->
      {{(rlps_pkg::FACT_W - rlps_pkg::IDX_W){1'b0}}, rsp.chosen_permutation} < FACT_MAX)
    else $error("chosen index out of range");

  // a query at index zero is always valid, so the block must go busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.action == rlps_pkg::ACT_QUERY &&
    req.permutation_index == '0 |=> req_stall)
    else $error("not busy after a query transaction");

endmodule

bind random_last_permutation_selector rlps_checker u_rlps_checker (.*);
